// ===== design/cayley_dickson_multiplier_top_macros.svh =====
// Assertion macros for the Cayley-Dickson multiplier top level.
`ifndef CAYLEY_DICKSON_MULTIPLIER_TOP_MACROS_SVH
`define CAYLEY_DICKSON_MULTIPLIER_TOP_MACROS_SVH

// same-cycle implication
`define CDM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdm assertion failed");

// next-cycle implication
`define CDM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdm assertion failed");

`endif

// ===== design/cdm_pkg.sv =====
// Shared constants, types and sign table function for the Cayley-Dickson multiplier.
`default_nettype none
package cdm_pkg;
  localparam int CDM_MAX_DIM   = 16;
  localparam int CDM_IDX_BITS  = 4;
  localparam int CDM_LG_BITS   = 3;
  localparam int CDM_LG_MAX    = 4;
  localparam int CDM_PART_BITS = 16;
  localparam int CDM_PROD_BITS = 32;
  localparam int CDM_ACC_BITS  = 36;
  localparam int CDM_SUM_BITS  = 64;
  localparam int CDM_ROOT_BITS = 32;
  localparam int CDM_NORM_BITS = 18;

  typedef logic [CDM_IDX_BITS-1:0] cdm_idx_t;
  typedef logic signed [CDM_PART_BITS-1:0] cdm_part_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MAC    = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_SQRT   = 6'b001000,
    ST_OUT_RD = 6'b010000,
    ST_OUT_LD = 6'b100000
  } cdm_state_t;

  // control that travels with one term through the MAC pipeline
  typedef struct packed {
    logic     valid;
    logic     first;
    logic     last;
    logic     done_run;
    logic     neg;
    cdm_idx_t k;
  } cdm_mac_ctl_t;

  // Sign of e_i * e_j (left basis i, right basis j) at dimension 2^lg.
  // Walks the doubling levels from the top, following the recursion.
  function automatic logic cdm_sign(input cdm_idx_t i, input cdm_idx_t j,
                                    input logic [CDM_LG_BITS-1:0] lg);
    cdm_idx_t a;
    cdm_idx_t b;
    cdm_idx_t t;
    logic     neg;
    a   = i;
    b   = j;
    neg = 1'b0;
    for (int lv = CDM_LG_MAX - 1; lv >= 0; lv--) begin
      if (lv < int'(lg)) begin
        case ({a[lv], b[lv]})
          2'b01: begin
            b[lv] = 1'b0;
            t = a; a = b; b = t;
          end
          2'b10: begin
            a[lv] = 1'b0;
            neg = neg ^ (b != '0);
          end
          2'b11: begin
            a[lv] = 1'b0;
            b[lv] = 1'b0;
            neg = neg ^ (b == '0);
            t = a; a = b; b = t;
          end
          default: ;
        endcase
      end
    end
    return neg;
  endfunction
endpackage
`default_nettype wire

// ===== design/cdm_channels.sv =====
// Valid/ready channel interfaces for operand pairs and product components.
`default_nettype none
interface cdm_in_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               component_index;
  logic signed [15:0]       left_part;
  logic signed [15:0]       right_part;
  logic                     final_pair;
  modport source (output valid, component_index, left_part, right_part, final_pair,
                  input ready);
  modport sink   (input valid, component_index, left_part, right_part, final_pair,
                  output ready);
endinterface

interface cdm_out_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               result_index;
  logic signed [31:0]       product_part;
  logic [17:0]              product_norm;
  logic                     end_of_run;
  modport source (output valid, result_index, product_part, product_norm, end_of_run,
                  input ready);
  modport sink   (input valid, result_index, product_part, product_norm, end_of_run,
                  output ready);
endinterface
`default_nettype wire

// ===== design/cayley_dickson_multiplier_top.sv =====
// Cayley-Dickson hypercomplex multiplier: operand stores, MAC sequencer, norm and output.
// Sequence: after the final pair run the n*n-term MAC sweep, pipeline drain, square root and
//   readout, then per component ST_OUT_RD and ST_OUT_LD; n = 2^dimension_log2, capped at 16.
// Throughput: one shared 16x16 multiplier reading both stores once per cycle gives n*n terms
//   per product; pairs are accepted only while the block is idle.
// Reset: dimension_log2 returns to 4, both operand stores read as zero, no output pending.
`default_nettype none
`include "cayley_dickson_multiplier_top_macros.svh"
module cayley_dickson_multiplier_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,
  cdm_in_if.sink          in_ch,
  cdm_out_if.source       out_ch
);
  import cdm_pkg::*;

  cdm_state_t                     state;
  logic [CDM_LG_BITS-1:0]         dim_lg;
  logic [CDM_LG_BITS-1:0]         lg;
  cdm_idx_t                       nm1;
  logic [CDM_MAX_DIM-1:0]         stored;     // entry written since reset
  cdm_idx_t                       i_cnt;
  cdm_idx_t                       k_cnt;
  cdm_idx_t                       j_idx;
  cdm_idx_t                       o_cnt;
  cdm_mac_ctl_t                   ctl0;
  cdm_mac_ctl_t                   ctl1;
  logic                           vl1;
  logic                           vr1;
  logic                           in_acc;
  logic                           st_we;
  logic                           st_re;
  logic [CDM_PART_BITS-1:0]       l_rd;
  logic [CDM_PART_BITS-1:0]       r_rd;
  logic signed [CDM_PART_BITS-1:0] x;
  logic signed [CDM_PART_BITS-1:0] y;
  logic                           res_we;
  cdm_idx_t                       res_addr;
  logic signed [CDM_ACC_BITS-1:0] res_data;
  logic [CDM_ACC_BITS-1:0]        res_rd;
  logic signed [CDM_ACC_BITS-1:0] res_v;
  logic [CDM_SUM_BITS-1:0]        sum;
  logic                           sat;
  logic                           mac_done;
  logic                           sq_done;
  logic [CDM_ROOT_BITS-1:0]       root;
  logic [CDM_NORM_BITS-1:0]       norm;
  logic                           load;
  logic signed [CDM_PROD_BITS-1:0] part_sat;

  // dimensions above sedenions fold to 16
  assign lg    = (dim_lg > CDM_LG_BITS'(CDM_LG_MAX)) ? CDM_LG_BITS'(CDM_LG_MAX) : dim_lg;
  assign nm1   = CDM_IDX_BITS'((5'd1 << lg) - 5'd1);
  assign j_idx = i_cnt ^ k_cnt;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign st_we       = in_acc;
  assign st_re       = (state == ST_MAC);

  // one term issued per cycle: r[k] += sign * x[i] * y[i^k]
  always_comb begin
    ctl0          = '0;
    ctl0.valid    = (state == ST_MAC);
    ctl0.first    = (i_cnt == '0);
    ctl0.last     = (i_cnt == nm1);
    ctl0.done_run = (i_cnt == nm1) && (k_cnt == nm1);
    ctl0.neg      = cdm_sign(i_cnt, j_idx, lg);
    ctl0.k        = k_cnt;
  end

  cdm_ram #(.WIDTH(CDM_PART_BITS), .DEPTH(CDM_MAX_DIM)) u_left (
    .clk(clk), .we(st_we), .waddr(in_ch.component_index), .wdata(in_ch.left_part),
    .re(st_re), .raddr(i_cnt), .rdata(l_rd)
  );

  cdm_ram #(.WIDTH(CDM_PART_BITS), .DEPTH(CDM_MAX_DIM)) u_right (
    .clk(clk), .we(st_we), .waddr(in_ch.component_index), .wdata(in_ch.right_part),
    .re(st_re), .raddr(j_idx), .rdata(r_rd)
  );

  // unwritten entries read as zero
  assign x = vl1 ? signed'(l_rd) : '0;
  assign y = vr1 ? signed'(r_rd) : '0;

  cdm_mac u_mac (
    .clk(clk), .rst(rst), .start(in_acc && in_ch.final_pair), .ctl(ctl1), .x(x), .y(y),
    .res_we(res_we), .res_addr(res_addr), .res_data(res_data),
    .sum(sum), .sat(sat), .done(mac_done)
  );

  cdm_ram #(.WIDTH(CDM_ACC_BITS), .DEPTH(CDM_MAX_DIM)) u_result (
    .clk(clk), .we(res_we), .waddr(res_addr), .wdata(res_data),
    .re(state == ST_OUT_RD), .raddr(o_cnt), .rdata(res_rd)
  );

  cdm_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(mac_done), .value(sum), .done(sq_done), .root(root)
  );

  // clamp the exact component to Q2.30
  always_comb begin
    res_v = signed'(res_rd);
    if (res_v[CDM_ACC_BITS-1:CDM_PROD_BITS-1] == '0 ||
        res_v[CDM_ACC_BITS-1:CDM_PROD_BITS-1] == '1) begin
      part_sat = res_v[CDM_PROD_BITS-1:0];
    end else if (res_v[CDM_ACC_BITS-1]) begin
      part_sat = {1'b1, {(CDM_PROD_BITS-1){1'b0}}};
    end else begin
      part_sat = {1'b0, {(CDM_PROD_BITS-1){1'b1}}};
    end
  end

  assign load = (state == ST_OUT_LD) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    vl1 <= stored[i_cnt];
    vr1 <= stored[j_idx];
    if (sq_done) begin
      norm <= sat ? '1 : root[CDM_ROOT_BITS-1:14];
    end
    if (load) begin
      out_ch.result_index <= o_cnt;
      out_ch.product_part <= part_sat;
      out_ch.product_norm <= norm;
      out_ch.end_of_run   <= (o_cnt == nm1);
    end
    if (rst) begin
      state        <= ST_IDLE;
      dim_lg       <= CDM_LG_BITS'(CDM_LG_MAX);
      stored       <= '0;
      i_cnt        <= '0;
      k_cnt        <= '0;
      o_cnt        <= '0;
      ctl1         <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      ctl1 <= ctl0;
      if (cfg_we) begin
        dim_lg <= cfg_wdata;
      end
      if (load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            stored[in_ch.component_index] <= 1'b1;
            if (in_ch.final_pair) begin
              i_cnt <= '0;
              k_cnt <= '0;
              state <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          if (i_cnt == nm1) begin
            i_cnt <= '0;
            k_cnt <= k_cnt + 1'b1;
            if (k_cnt == nm1) begin
              state <= ST_DRAIN;
            end
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            o_cnt <= '0;
            state <= ST_OUT_RD;
          end
        end
        ST_OUT_RD: begin
          state <= ST_OUT_LD;
        end
        ST_OUT_LD: begin
          if (load) begin
            o_cnt <= o_cnt + 1'b1;
            state <= (o_cnt == nm1) ? ST_IDLE : ST_OUT_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a final pair always launches the MAC sweep
  `CDM_ASSERT_NXT(a_final_starts, in_ch.valid && in_ch.ready && in_ch.final_pair, state == ST_MAC)
  // the closing transaction carries the top component index
  `CDM_ASSERT_IMP(a_eor_index, out_ch.valid && out_ch.end_of_run, out_ch.result_index == nm1)
  // component writes only land while the sweep runs or drains
  `CDM_ASSERT_IMP(a_res_phase, res_we, state == ST_MAC || state == ST_DRAIN)
endmodule
`default_nettype wire

// ===== design/cdm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== design/cdm_mac.sv =====
// Multiply-accumulate pipeline: signed terms into components, squares into the norm sum.
`default_nettype none
module cdm_mac (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire cdm_pkg::cdm_mac_ctl_t    ctl,
  input  wire logic signed [15:0]       x,
  input  wire logic signed [15:0]       y,
  output logic                          res_we,
  output cdm_pkg::cdm_idx_t             res_addr,
  output logic signed [35:0]            res_data,
  output logic [63:0]                   sum,
  output logic                          sat,
  output logic                          done
);
  import cdm_pkg::*;

  cdm_mac_ctl_t                     ctl2;
  logic signed [CDM_PROD_BITS-1:0]  prod;
  logic signed [CDM_ACC_BITS-1:0]   acc;
  logic signed [CDM_ACC_BITS-1:0]   acc_next;
  logic signed [CDM_ACC_BITS-1:0]   term;
  logic                             sq_v;
  logic                             sq_end;
  logic signed [CDM_ACC_BITS-1:0]   sq_acc;
  logic [CDM_ACC_BITS-1:0]          mag;
  logic                             fin_v;
  logic                             fin_end;
  logic                             fin_big;
  logic [CDM_SUM_BITS-1:0]          sq;
  logic [CDM_SUM_BITS:0]            sum_add;

  always_comb begin
    term     = ctl2.neg ? -CDM_ACC_BITS'(prod) : CDM_ACC_BITS'(prod);
    acc_next = ctl2.first ? term : acc + term;
    mag      = sq_acc[CDM_ACC_BITS-1] ? CDM_ACC_BITS'(-sq_acc) : CDM_ACC_BITS'(sq_acc);
    sum_add  = {1'b0, sum} + {1'b0, sq};
  end

  assign res_we   = ctl2.valid && ctl2.last;
  assign res_addr = ctl2.k;
  assign res_data = acc_next;

  always_ff @(posedge clk) begin
    prod <= x * y;
    if (ctl2.valid) begin
      acc <= acc_next;
    end
    sq_acc  <= acc_next;
    sq      <= CDM_SUM_BITS'(mag[31:0]) * CDM_SUM_BITS'(mag[31:0]);
    fin_big <= mag[CDM_ACC_BITS-1:32] != '0;
    if (rst) begin
      ctl2    <= '0;
      sq_v    <= 1'b0;
      sq_end  <= 1'b0;
      fin_v   <= 1'b0;
      fin_end <= 1'b0;
      done    <= 1'b0;
      sum     <= '0;
      sat     <= 1'b0;
    end else begin
      ctl2    <= ctl;
      sq_v    <= res_we;
      sq_end  <= res_we && ctl2.done_run;
      fin_v   <= sq_v;
      fin_end <= sq_v && sq_end;
      done    <= fin_v && fin_end;
      if (start) begin
        sum <= '0;
        sat <= 1'b0;
      end else if (fin_v) begin
        if (fin_big || sum_add[CDM_SUM_BITS]) begin
          sat <= 1'b1;
        end else begin
          sum <= sum_add[CDM_SUM_BITS-1:0];
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/cdm_isqrt.sv =====
// Bit-by-bit integer square root, one result bit per cycle.
`default_nettype none
module cdm_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] value,
  output logic             done,
  output logic [31:0]      root
);
  import cdm_pkg::*;

  logic                    busy;
  logic [CDM_SUM_BITS-1:0] rem;
  logic [CDM_SUM_BITS-1:0] res;
  logic [CDM_SUM_BITS-1:0] bitv;
  logic [CDM_SUM_BITS-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[CDM_ROOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= CDM_SUM_BITS'(1) << (CDM_SUM_BITS - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (bitv == CDM_SUM_BITS'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (bitv == CDM_SUM_BITS'(1))) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
